// ===== rtl/core/lr4_crossover_filter_top_defines.svh =====
`ifndef LR4_CROSSOVER_FILTER_TOP_DEFINES_SVH
`define LR4_CROSSOVER_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define LR4X_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define LR4X_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lr4x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lr4x_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int STATE_W    = 40;
  localparam int PROD_W     = COEF_W + SAMPLE_W;
  localparam int PROD_SHIFT = 23;
  localparam int RND_W      = PROD_W - PROD_SHIFT;
  localparam int ACC_W      = STATE_W + 2;
  localparam int ACC2_W     = RND_W + 1;
  localparam int OUT_SHIFT  = 7;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [RND_W-1:0]    rnd_t;
  typedef logic signed [STATE_W-1:0]  state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_B0,
    REG_LOW_B1,
    REG_LOW_B2,
    REG_HIGH_B0,
    REG_HIGH_B1,
    REG_HIGH_B2,
    REG_FB_A1,
    REG_FB_A2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/lr4_crossover_filter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake                  | payload
// ---------+----------------------------+---------------------------------
// sample   | sample_valid, sample_stall | sample (Q1.23)
// band     | band_valid, band_stall     | low_sample, high_sample (Q1.23)
// config   | cfg_write                  | cfg_index, cfg_data (Q2.30)
//
// each word runs through 2*STAGES biquad sections; each section takes five
// products through the single shared multiplier plus a state write-back.
// sample_stall is high from acceptance until the band word is registered.
// a band word waiting under band_stall holds the last low and last high write-backs.
// rst is synchronous: coefficients and section states clear to zero.

module lr4_crossover_filter_top #(
  parameter int STAGES = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lr4x_pkg::sample_t                   sample,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  output lr4x_pkg::sample_t                   low_sample,
  output lr4x_pkg::sample_t                   high_sample,
  output logic                                band_valid,
  input  logic                                band_stall,
  input  logic                                cfg_write,
  input  logic [lr4x_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  lr4x_pkg::coef_t                     cfg_data
);
  import lr4x_pkg::*;

  `include "lr4_crossover_filter_top_defines.svh"

  localparam int SECTIONS = 2 * STAGES;
  localparam int CW       = $clog2(SECTIONS);
  localparam int DEPTH    = 2 * SECTIONS;
  localparam int SW       = CW + 1;
  localparam logic [CW-1:0] LAST_LOW  = CW'(STAGES - 1);
  localparam logic [CW-1:0] LAST_SEC  = CW'(SECTIONS - 1);
  localparam logic [CW-1:0] FIRST_HI  = CW'(STAGES);
  localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) << (OUT_SHIFT - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_B0,
    PH_B1,
    PH_B2,
    PH_A1,
    PH_A2,
    PH_STORE
  } phase_t;

  phase_t                     phase;
  logic [CW-1:0]              sec;
  coef_t                      coef_reg [NUM_REGS];
  state_t                     st [DEPTH];
  sample_t                    x;
  sample_t                    y;
  sample_t                    sample_hold;
  logic signed [ACC_W-1:0]    acc;
  logic signed [RND_W-1:0]    acc2;

  coef_t                      mul_coef;
  sample_t                    mul_op;
  rnd_t                       rnd;
  logic                       band_hi;
  logic [SW-1:0]              rd_idx;
  logic [SW-1:0]              s0_idx;
  logic [SW-1:0]              s1_idx;
  logic signed [ACC_W-1:0]    sum_s;
  logic signed [ACC_W-1:0]    acc_sub;
  logic signed [ACC_W-1:0]    y_biased;
  logic signed [ACC_W-OUT_SHIFT-1:0] y_shift;
  sample_t                    y_sat;
  state_t                     s0_new;
  logic signed [ACC2_W-1:0]   s1_diff;
  state_t                     s1_new;
  logic                       hold_store;
  logic                       band_load;
  logic                       fits_y;
  logic                       fits_s0;

  lr4x_mac u_mac (
    .clk      (clk),
    .coef     (mul_coef),
    .operand  (mul_op),
    .prod_rnd (rnd)
  );

  assign sample_stall = (phase != PH_IDLE);
  assign band_hi      = (sec >= FIRST_HI);
  assign s0_idx       = {sec, 1'b0};
  assign s1_idx       = {sec, 1'b1};
  assign rd_idx       = (phase == PH_B2) ? s1_idx : s0_idx;

  // operand select for the shared multiplier
  always_comb begin
    mul_coef = coef_reg[REG_FB_A2];
    mul_op   = y;
    case (phase)
      PH_B0: begin
        mul_coef = band_hi ? coef_reg[REG_HIGH_B0] : coef_reg[REG_LOW_B0];
        mul_op   = x;
      end
      PH_B1: begin
        mul_coef = band_hi ? coef_reg[REG_HIGH_B1] : coef_reg[REG_LOW_B1];
        mul_op   = x;
      end
      PH_B2: begin
        mul_coef = band_hi ? coef_reg[REG_HIGH_B2] : coef_reg[REG_LOW_B2];
        mul_op   = x;
      end
      PH_A1: begin
        mul_coef = coef_reg[REG_FB_A1];
        mul_op   = y;
      end
      // store keeps a2*y so a held write-back sees the same product
      default: begin
        mul_coef = coef_reg[REG_FB_A2];
        mul_op   = y;
      end
    endcase
  end

  always_comb begin
    sum_s    = ACC_W'(rnd) + ACC_W'(st[rd_idx]);
    acc_sub  = acc - ACC_W'(rnd);
    y_biased = acc + OUT_HALF;
    y_shift  = y_biased[ACC_W-1:OUT_SHIFT];
    fits_y   = (&y_shift[ACC_W-OUT_SHIFT-1:SAMPLE_W-1]) |
               ~(|y_shift[ACC_W-OUT_SHIFT-1:SAMPLE_W-1]);
    if (fits_y) begin
      y_sat = y_shift[SAMPLE_W-1:0];
    end else begin
      y_sat = {y_shift[ACC_W-OUT_SHIFT-1], {(SAMPLE_W-1){~y_shift[ACC_W-OUT_SHIFT-1]}}};
    end
    fits_s0 = (&acc[ACC_W-1:STATE_W-1]) | ~(|acc[ACC_W-1:STATE_W-1]);
    if (fits_s0) begin
      s0_new = acc[STATE_W-1:0];
    end else begin
      s0_new = {acc[ACC_W-1], {(STATE_W-1){~acc[ACC_W-1]}}};
    end
    // b2*x - a2*y always fits the state width
    s1_diff = ACC2_W'(acc2) - ACC2_W'(rnd);
    s1_new  = STATE_W'(s1_diff);
  end

  // both band outputs stay put while the previous word waits
  assign hold_store = ((sec == LAST_SEC) || (sec == LAST_LOW)) && band_valid && band_stall;
  assign band_load  = (phase == PH_STORE) && (sec == LAST_SEC) && !hold_store;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      sec        <= '0;
      band_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_reg[i] <= '0;
      end
      for (int i = 0; i < DEPTH; i++) begin
        st[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        coef_reg[cfg_index] <= cfg_data;
      end
      if (band_load) begin
        band_valid <= 1'b1;
      end else if (band_valid && !band_stall) begin
        band_valid <= 1'b0;
      end
      case (phase)
        PH_IDLE: begin
          if (sample_valid) begin
            x           <= sample;
            sample_hold <= sample;
            sec         <= '0;
            phase       <= PH_B0;
          end
        end
        PH_B0: begin
          phase <= PH_B1;
        end
        PH_B1: begin
          acc   <= sum_s;
          phase <= PH_B2;
        end
        PH_B2: begin
          y     <= y_sat;
          acc   <= sum_s;
          phase <= PH_A1;
        end
        PH_A1: begin
          acc2  <= rnd;
          phase <= PH_A2;
        end
        PH_A2: begin
          acc   <= acc_sub;
          phase <= PH_STORE;
        end
        PH_STORE: begin
          if (!hold_store) begin
            st[s0_idx] <= s0_new;
            st[s1_idx] <= s1_new;
            if (sec == LAST_SEC) begin
              high_sample <= y;
              sec         <= '0;
              phase       <= PH_IDLE;
            end else begin
              if (sec == LAST_LOW) begin
                low_sample <= y;
                x          <= sample_hold;
              end else begin
                x <= y;
              end
              sec   <= sec + CW'(1);
              phase <= PH_B0;
            end
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  `LR4X_CHECK_NEXT(a_accept_starts, sample_valid && !sample_stall,
    phase == PH_B0 && sec == '0, "accepted word did not start at the first section")
  `LR4X_CHECK_NEXT(a_store_holds, phase == PH_STORE && hold_store,
    phase == PH_STORE && band_valid, "write-back advanced while band word waits")
  `LR4X_CHECK_NOW(a_result_from_store, $rose(band_valid),
    $past(phase == PH_STORE) && phase == PH_IDLE, "band word set outside write-back")
  `LR4X_CHECK_NOW(a_section_bound, phase != PH_IDLE,
    sec <= LAST_SEC, "section counter past last section")

endmodule

`default_nettype wire

// ===== rtl/core/lr4x_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lr4x_mac (
  input  logic               clk,
  input  lr4x_pkg::coef_t    coef,
  input  lr4x_pkg::sample_t  operand,
  output lr4x_pkg::rnd_t     prod_rnd
);
  import lr4x_pkg::*;

  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (PROD_SHIFT - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_biased;

  // full Q3.53 product, registered before rounding
  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef) * PROD_W'(operand);
  end

  // round to 30 fraction bits: add half, floor shift
  assign prod_biased = prod + PROD_HALF;
  assign prod_rnd    = prod_biased[PROD_W-1 -: RND_W];

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lr4x_pkg::*;

  localparam int SECTIONS = 2;
  localparam int QUIET_LIMIT = 4000;
  localparam int LOW_BAND = 0;
  localparam int HIGH_BAND = 1;
  localparam longint STATE_HI = 64'sd549755813887;
  localparam longint STATE_LO = -64'sd549755813888;
  localparam longint WORD_HI = 64'sd8388607;
  localparam longint WORD_LO = -64'sd8388608;
  localparam coef_t UNITY = 32'sd1073741824;

  typedef struct packed {
    sample_t low;
    sample_t high;
  } band_word_t;

  typedef coef_t coef_bank_t [NUM_REGS];

  logic clk = 1'b0;
  logic rst = 1'b1;
  sample_t sample = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t low_sample;
  sample_t high_sample;
  logic band_valid;
  logic band_stall = 1'b0;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coef_t cfg_data = '0;

  // mirror of the coefficient registers and section states
  longint coef_mirror [NUM_REGS] = '{default: 0};
  longint band_state [2][2*SECTIONS] = '{default: '{default: 0}};

  band_word_t band_expect_q [$];
  int idle_pct = 32;
  int words_sent = 0;
  int words_checked = 0;
  int mismatch_count = 0;
  int coef_sets_loaded = 0;
  int quiet_cycles = 0;

  lr4_crossover_filter_top #(
    .STAGES(SECTIONS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample(sample),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .low_sample(low_sample),
    .high_sample(high_sample),
    .band_valid(band_valid),
    .band_stall(band_stall),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Q2.30 coefficient times Q1.23 sample, rounded back to 30 fraction bits
  function automatic longint coef_times(longint c, longint x);
    return (c * x + 64'sd4194304) >>> 23;
  endfunction

  function automatic sample_t run_band(sample_t x_in, int band, longint b0, longint b1,
                                       longint b2);
    longint a1;
    longint a2;
    longint x;
    longint acc;
    longint y;
    longint n0;
    longint n1;
    a1 = coef_mirror[REG_FB_A1];
    a2 = coef_mirror[REG_FB_A2];
    x = x_in;
    for (int k = 0; k < SECTIONS; k++) begin
      acc = coef_times(b0, x) + band_state[band][2*k];
      y = clip((acc + 64) >>> 7, WORD_LO, WORD_HI);
      n0 = coef_times(b1, x) - coef_times(a1, y) + band_state[band][2*k+1];
      n1 = coef_times(b2, x) - coef_times(a2, y);
      band_state[band][2*k] = clip(n0, STATE_LO, STATE_HI);
      band_state[band][2*k+1] = clip(n1, STATE_LO, STATE_HI);
      x = y;
    end
    return sample_t'(x);
  endfunction

  function automatic band_word_t predict_bands(sample_t x);
    band_word_t w;
    w.low = run_band(x, LOW_BAND, coef_mirror[REG_LOW_B0], coef_mirror[REG_LOW_B1],
                     coef_mirror[REG_LOW_B2]);
    w.high = run_band(x, HIGH_BAND, coef_mirror[REG_HIGH_B0], coef_mirror[REG_HIGH_B1],
                      coef_mirror[REG_HIGH_B2]);
    return w;
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return sample_t'($urandom_range(511)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // butterworth pair at fc/fs = 0.05, cascaded twice per band
  function automatic coef_bank_t crossover_bank();
    coef_bank_t b;
    b[REG_LOW_B0] = 32'sd21563957;
    b[REG_LOW_B1] = 32'sd43127914;
    b[REG_LOW_B2] = 32'sd21563957;
    b[REG_HIGH_B0] = 32'sd859626967;
    b[REG_HIGH_B1] = -32'sd1719253934;
    b[REG_HIGH_B2] = 32'sd859626967;
    b[REG_FB_A1] = -32'sd1676132461;
    b[REG_FB_A2] = 32'sd688644318;
    return b;
  endfunction

  function automatic coef_bank_t flat_bank(coef_t v);
    coef_bank_t b;
    foreach (b[i]) b[i] = v;
    return b;
  endfunction

  function automatic coef_bank_t random_bank(bit near_crossover);
    coef_bank_t b;
    b = crossover_bank();
    foreach (b[i]) begin
      if (near_crossover) begin
        b[i] = b[i] + coef_t'($urandom_range(1048575)) - coef_t'(524288);
      end else begin
        case ($urandom_range(7))
          0: b[i] = 32'sh7fffffff;
          1: b[i] = 32'sh80000000;
          2: b[i] = coef_t'($urandom_range(65535)) - coef_t'(32768);
          default: b[i] = coef_t'($urandom);
        endcase
      end
    end
    return b;
  endfunction

  task automatic push_sample(input sample_t value);
    if ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(40, 1)) @(negedge clk);
    end
    sample <= value;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    band_expect_q.push_back(predict_bands(value));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_bands();
    sample_valid <= 1'b0;
    while (band_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one register per cycle, all eight in index order
  task automatic load_coefs(input coef_bank_t bank);
    cfg_reg_t r;
    r = r.first();
    do begin
      cfg_write <= 1'b1;
      cfg_index <= r;
      cfg_data <= bank[r];
      coef_mirror[r] = bank[r];
      @(negedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_write <= 1'b0;
    coef_sets_loaded++;
  endtask

  task automatic push_corners();
    sample_t corner_vals [5] = '{24'sh7fffff, 24'sh800000, 24'sd0, -24'sd1, 24'sd1};
    foreach (corner_vals[i]) push_sample(corner_vals[i]);
    drain_bands();
  endtask

  task automatic test_cleared_coefs();
    push_corners();
  endtask

  // low passes the sample; high negates it per section, clips at full scale
  task automatic test_unity_gain();
    coef_bank_t b;
    b = flat_bank('0);
    b[REG_LOW_B0] = UNITY;
    b[REG_HIGH_B0] = -UNITY;
    load_coefs(b);
    push_corners();
  endtask

  task automatic test_output_clipping();
    load_coefs(flat_bank(32'sh7fffffff));
    push_corners();
    load_coefs(flat_bank(32'sh80000000));
    push_corners();
  endtask

  task automatic test_crossover_random();
    load_coefs(crossover_bank());
    repeat (500) push_sample(random_sample());
    drain_bands();
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    repeat (300) push_sample(random_sample());
    drain_bands();
    idle_pct = 32;
  endtask

  task automatic test_random_coefs();
    for (int phase = 0; phase < 12; phase++) begin
      load_coefs(random_bank(phase % 2 == 0));
      repeat (95) push_sample(random_sample());
      drain_bands();
    end
  endtask

  always @(negedge clk) begin
    band_stall <= !rst && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    band_word_t want;
    if (!rst && band_valid && !band_stall) begin
      if (band_expect_q.size() == 0) begin
        $display("%0t: band word with none expected, low %0d high %0d", $time, low_sample,
                 high_sample);
        mismatch_count++;
      end else begin
        want = band_expect_q.pop_front();
        words_checked++;
        if (low_sample !== want.low) begin
          $display("%0t: low_sample mismatch, expected %0d, actual %0d", $time, want.low,
                   low_sample);
          mismatch_count++;
        end
        if (high_sample !== want.high) begin
          $display("%0t: high_sample mismatch, expected %0d, actual %0d", $time, want.high,
                   high_sample);
          mismatch_count++;
        end
      end
    end
  end

  // counts cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (band_valid && !band_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d band words outstanding", $time,
               QUIET_LIMIT, band_expect_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_cleared_coefs();
    test_unity_gain();
    test_output_clipping();
    test_crossover_random();
    test_back_to_back();
    test_random_coefs();
    repeat (30) @(negedge clk);
    $display("sent %0d samples, checked %0d band words over %0d coefficient sets",
             words_sent, words_checked, coef_sets_loaded);
    $display("phases: cleared, unity, clipping, crossover, back-to-back, random coefficients");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
